// File: sv/cfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the chunked frame reassembler: opcodes,
// result status codes, default store sizes and the result record.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // default frame store sizes in bytes
  localparam int unsigned DATA_STORE_BYTES_DEF = 512;
  localparam int unsigned LOG_STORE_BYTES_DEF  = 512;

  // fixed field widths
  localparam int unsigned ADDR_W  = 9;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned COUNT_W = 32;

  // channel numbers
  localparam logic CH_DATA = 1'b0;
  localparam logic CH_LOG  = 1'b1;

  typedef enum logic [1:0] {
    OP_CHUNK = 2'd0,
    OP_READ  = 2'd1,
    OP_BUMP  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DONE     = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // one result record as held in the output queue
  typedef struct packed {
    logic [2:0]         status;
    logic               out_channel;
    logic [LEN_W-1:0]   frame_len;
    logic [COUNT_W-1:0] frame_count;
    logic [7:0]         read_data;
  } result_t;

endpackage : cfr_pkg
`default_nettype wire

// File: sv/cfr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_ifs
// Valid/ready channel interfaces of the reassembler: one for input items,
// one for result items.
// ----------------------------------------------------------------------------
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       channel;
  logic [7:0] seq_tag;
  logic [7:0] chunk_number;
  logic [7:0] chunk_total;
  logic       chunk_start;
  logic       chunk_end;
  logic       has_byte;
  logic [7:0] data_byte;
  logic [8:0] read_addr;

  modport source (
    output valid, opcode, channel, seq_tag, chunk_number, chunk_total,
           chunk_start, chunk_end, has_byte, data_byte, read_addr,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, seq_tag, chunk_number, chunk_total,
           chunk_start, chunk_end, has_byte, data_byte, read_addr,
    output ready
  );
endinterface : cfr_in_if

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        out_channel;
  logic [9:0]  frame_len;
  logic [31:0] frame_count;
  logic [7:0]  read_data;

  modport source (
    output valid, status, out_channel, frame_len, frame_count, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, out_channel, frame_len, frame_count, read_data,
    output ready
  );
endinterface : cfr_out_if
`default_nettype wire

// File: sv/chunk_frame_reassembler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_frame_reassembler_core
// Rebuilds data and log frames from numbered chunks into two byte stores.
// ----------------------------------------------------------------------------
// The block takes one item per clock while input ready is high and returns
// one result per item, in order: on the transfer it runs the header checks
// on the per-channel frame registers and does the single store write or
// store read, then the result stage holds the registered read byte while the
// result enters a three-entry output queue. Store contents are not cleared
// by reset or by the clear opcode; a byte read back is only meaningful once
// a frame has written it. Input ready is high while queue and result stage
// together hold two results or fewer; a stalled sink stops intake at three.
module chunk_frame_reassembler_core
  import cfr_pkg::*;
#(
  parameter int unsigned DATA_STORE_BYTES = DATA_STORE_BYTES_DEF,
  parameter int unsigned LOG_STORE_BYTES  = LOG_STORE_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  cfr_in_if.sink     in_chan,
  cfr_out_if.source  out_chan
);

  localparam int unsigned MAX_BYTES =
    (DATA_STORE_BYTES > LOG_STORE_BYTES) ? DATA_STORE_BYTES : LOG_STORE_BYTES;
  localparam int unsigned GL_W  = $clog2(MAX_BYTES + 1);
  localparam int unsigned DA_W  = $clog2(DATA_STORE_BYTES);
  localparam int unsigned LA_W  = $clog2(LOG_STORE_BYTES);
  localparam int unsigned CMP_W = GL_W + ADDR_W;
  localparam logic [GL_W-1:0] DATA_SIZE = GL_W'(DATA_STORE_BYTES);
  localparam logic [GL_W-1:0] LOG_SIZE  = GL_W'(LOG_STORE_BYTES);

  // configuration
  logic log_sub_r;

  // per-channel frame registers
  logic [1:0]      frame_active_r, frame_active_nxt;
  logic [1:0]      chunk_good_r,   chunk_good_nxt;
  logic [7:0]      active_seq_r   [2];
  logic [7:0]      active_seq_nxt [2];
  logic [7:0]      active_tot_r   [2];
  logic [7:0]      active_tot_nxt [2];
  logic [7:0]      exp_idx_r      [2];
  logic [7:0]      exp_idx_nxt    [2];
  logic [GL_W-1:0] gath_len_r     [2];
  logic [GL_W-1:0] gath_len_nxt   [2];
  logic [COUNT_W-1:0] frame_cnt_r, frame_cnt_nxt;

  // frame stores
  logic [7:0] data_mem [DATA_STORE_BYTES];
  logic [7:0] log_mem  [LOG_STORE_BYTES];
  logic [7:0] data_rd_r, log_rd_r;

  // results computed on the transfer
  logic            in_xfer;
  logic            mem_we;
  logic [GL_W-1:0] mem_waddr;
  status_t         st_c;
  logic            och_c;
  logic [GL_W-1:0] len_c;
  logic            rd_oor_c;
  logic [CMP_W-1:0] rd_addr_ext;
  logic [CMP_W-1:0] rd_size_ext;

  // pipeline stage holding the result while the store read lands
  logic            p_valid_r;
  status_t         p_status_r;
  logic            p_och_r;
  logic [LEN_W-1:0] p_len_r;
  logic [COUNT_W-1:0] p_cnt_r;
  logic            p_is_read_r;
  logic            p_oor_r;
  logic [GL_W+LEN_W-1:0] len_ext;
  result_t         p_result;

  // output queue
  result_t    q_mem_r [3];
  logic [1:0] q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic [2:0] occupancy;
  logic       q_push, q_pop;

  assign in_xfer = in_chan.valid && in_chan.ready;

  // room for everything already in flight plus the new transfer
  assign occupancy     = 3'(q_cnt_r) + 3'(p_valid_r);
  assign in_chan.ready = (occupancy <= 3'd2);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_sub_r <= 1'b0;
    end else if (cfg_we) begin
      log_sub_r <= cfg_wdata;
    end
  end

  // read range check against the addressed channel's store
  assign rd_addr_ext = CMP_W'(in_chan.read_addr);
  assign rd_size_ext = CMP_W'(in_chan.channel ? LOG_SIZE : DATA_SIZE);
  assign rd_oor_c    = (rd_addr_ext >= rd_size_ext);

  // header checks, store write decision and frame register update
  always_comb begin
    logic            ch;
    logic            go;
    logic [GL_W-1:0] size_c;
    logic [7:0]      idx_inc;
    frame_active_nxt = frame_active_r;
    chunk_good_nxt   = chunk_good_r;
    active_seq_nxt   = active_seq_r;
    active_tot_nxt   = active_tot_r;
    exp_idx_nxt      = exp_idx_r;
    gath_len_nxt     = gath_len_r;
    frame_cnt_nxt    = frame_cnt_r;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    st_c             = ST_OK;
    ch               = in_chan.channel;
    och_c            = ch;
    len_c            = '0;
    go               = 1'b1;
    size_c           = ch ? LOG_SIZE : DATA_SIZE;
    idx_inc          = '0;

    case (opcode_t'(in_chan.opcode))
      OP_CHUNK: begin
        if (ch == CH_LOG && !log_sub_r) begin
          st_c = ST_IGNORED;
          go   = 1'b0;
        end
        // header checks on the first item of a chunk
        if (go && in_chan.chunk_start) begin
          chunk_good_nxt[ch] = 1'b0;
          if (in_chan.chunk_total == 8'd0) begin
            st_c = ST_IGNORED;
            go   = 1'b0;
          end else if (in_chan.chunk_number == 8'd0) begin
            frame_active_nxt[ch] = 1'b1;
            active_seq_nxt[ch]   = in_chan.seq_tag;
            active_tot_nxt[ch]   = in_chan.chunk_total;
            exp_idx_nxt[ch]      = 8'd0;
            gath_len_nxt[ch]     = '0;
          end else if (!frame_active_r[ch]) begin
            st_c = ST_IGNORED;
            go   = 1'b0;
          end
          if (go) begin
            if (in_chan.seq_tag != active_seq_nxt[ch] ||
                in_chan.chunk_number != exp_idx_nxt[ch] ||
                in_chan.chunk_total != active_tot_nxt[ch]) begin
              frame_active_nxt[ch] = 1'b0;
              st_c = ST_MISMATCH;
              go   = 1'b0;
            end else begin
              chunk_good_nxt[ch] = 1'b1;
            end
          end
        end
        // stray item of an ignored or aborted chunk
        if (go && !chunk_good_nxt[ch]) begin
          st_c = ST_IGNORED;
          go   = 1'b0;
        end
        // payload byte into the store
        if (go && in_chan.has_byte) begin
          if (gath_len_nxt[ch] >= size_c) begin
            frame_active_nxt[ch] = 1'b0;
            chunk_good_nxt[ch]   = 1'b0;
            st_c = ST_OVERFLOW;
            go   = 1'b0;
          end else begin
            mem_we           = 1'b1;
            mem_waddr        = gath_len_nxt[ch];
            gath_len_nxt[ch] = gath_len_nxt[ch] + 1'b1;
          end
        end
        // chunk commit and frame completion
        if (go && in_chan.chunk_end) begin
          chunk_good_nxt[ch] = 1'b0;
          idx_inc            = exp_idx_nxt[ch] + 8'd1;
          exp_idx_nxt[ch]    = idx_inc;
          if (idx_inc >= active_tot_nxt[ch]) begin
            frame_active_nxt[ch] = 1'b0;
            if (ch == CH_DATA) begin
              frame_cnt_nxt = frame_cnt_r + 1'b1;
            end
            st_c = ST_DONE;
          end
        end
        len_c = gath_len_nxt[ch];
      end
      OP_READ: begin
        len_c = gath_len_r[ch];
      end
      OP_BUMP: begin
        frame_cnt_nxt = frame_cnt_r + 1'b1;
        och_c         = CH_DATA;
      end
      OP_CLEAR: begin
        frame_active_nxt = '0;
        chunk_good_nxt   = '0;
        for (int i = 0; i < 2; i++) begin
          active_seq_nxt[i] = '0;
          active_tot_nxt[i] = '0;
          exp_idx_nxt[i]    = '0;
          gath_len_nxt[i]   = '0;
        end
        frame_cnt_nxt = '0;
        och_c         = CH_DATA;
      end
      default: begin
        st_c = ST_OK;
      end
    endcase
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= '0;
      chunk_good_r   <= '0;
      frame_cnt_r    <= '0;
      for (int i = 0; i < 2; i++) begin
        active_seq_r[i] <= '0;
        active_tot_r[i] <= '0;
        exp_idx_r[i]    <= '0;
        gath_len_r[i]   <= '0;
      end
    end else if (in_xfer) begin
      frame_active_r <= frame_active_nxt;
      chunk_good_r   <= chunk_good_nxt;
      frame_cnt_r    <= frame_cnt_nxt;
      for (int i = 0; i < 2; i++) begin
        active_seq_r[i] <= active_seq_nxt[i];
        active_tot_r[i] <= active_tot_nxt[i];
        exp_idx_r[i]    <= exp_idx_nxt[i];
        gath_len_r[i]   <= gath_len_nxt[i];
      end
    end
  end

  // data store: one write or one read per transfer
  always_ff @(posedge clk) begin
    if (in_xfer && mem_we && in_chan.channel == CH_DATA) begin
      data_mem[mem_waddr[DA_W-1:0]] <= in_chan.data_byte;
    end
    if (in_xfer && opcode_t'(in_chan.opcode) == OP_READ) begin
      data_rd_r <= data_mem[rd_addr_ext[DA_W-1:0]];
    end
  end

  // log store: one write or one read per transfer
  always_ff @(posedge clk) begin
    if (in_xfer && mem_we && in_chan.channel == CH_LOG) begin
      log_mem[mem_waddr[LA_W-1:0]] <= in_chan.data_byte;
    end
    if (in_xfer && opcode_t'(in_chan.opcode) == OP_READ) begin
      log_rd_r <= log_mem[rd_addr_ext[LA_W-1:0]];
    end
  end

  // result stage alongside the store read
  assign len_ext = (GL_W + LEN_W)'(len_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_status_r  <= st_c;
      p_och_r     <= och_c;
      p_len_r     <= len_ext[LEN_W-1:0];
      p_cnt_r     <= frame_cnt_nxt;
      p_is_read_r <= (opcode_t'(in_chan.opcode) == OP_READ);
      p_oor_r     <= rd_oor_c;
    end
  end

  always_comb begin
    p_result.status      = p_status_r;
    p_result.out_channel = p_och_r;
    p_result.frame_len   = p_len_r;
    p_result.frame_count = p_cnt_r;
    p_result.read_data   = '0;
    if (p_is_read_r && !p_oor_r) begin
      p_result.read_data = p_och_r ? log_rd_r : data_rd_r;
    end
  end

  // output queue, three entries
  assign q_push = p_valid_r;
  assign q_pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wp_r <= (q_wp_r == 2'd2) ? 2'd0 : q_wp_r + 2'd1;
      end
      if (q_pop) begin
        q_rp_r <= (q_rp_r == 2'd2) ? 2'd0 : q_rp_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wp_r] <= p_result;
    end
  end

  // result channel
  assign out_chan.valid       = (q_cnt_r != 2'd0);
  assign out_chan.status      = q_mem_r[q_rp_r].status;
  assign out_chan.out_channel = q_mem_r[q_rp_r].out_channel;
  assign out_chan.frame_len   = q_mem_r[q_rp_r].frame_len;
  assign out_chan.frame_count = q_mem_r[q_rp_r].frame_count;
  assign out_chan.read_data   = q_mem_r[q_rp_r].read_data;

endmodule : chunk_frame_reassembler_core
`default_nettype wire

// File: sv/cfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks of the reassembler, bound to the core module.
// ----------------------------------------------------------------------------
module cfr_checker
  import cfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_frame_count,
  input wire logic [7:0]  out_read_data
);

  // no result appears straight out of reset
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // intake only stops while results are waiting
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // only a store read carries a byte, and a read always reports ok
  a_read_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'd0 |-> out_status == ST_OK)
    else $error("read byte on a result that is not a store read");

  // a stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_frame_count) &&
      $stable(out_read_data))
    else $error("result changed while stalled");

endmodule : cfr_checker

bind chunk_frame_reassembler_core cfr_checker u_cfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_frame_count (out_chan.frame_count),
  .out_read_data   (out_chan.read_data)
);
`default_nettype wire
